FILE: src/cle_pkg.sv
package cle_pkg;

	localparam int MaxClasses = 16;
	localparam int MaxRows = 65536;
	localparam int IdxW = $clog2(MaxClasses);
	localparam int UsedW = $clog2(MaxClasses + 1);
	localparam int CntW = $clog2(MaxRows + 1);
	localparam int LogW = 21;
	localparam int AccW = CntW + LogW + IdxW + 1;

	localparam logic RES_LABEL = 1'b0;
	localparam logic RES_ENTROPY = 1'b1;

	typedef enum logic [2:0] {
		ST_COUNT,
		ST_EMIT,
		ST_LOGN,
		ST_LOGC,
		ST_DIV,
		ST_DONE
	} state_t;

	// one cell of the label table
	typedef struct packed {
		logic             vld;
		logic [31:0]      key;
		logic [CntW-1:0]  cnt;
	} cell_t;

	// control from the sequencer to every cell
	typedef struct packed {
		logic        clr;
		logic        upd;
		logic        ins;
		logic        shift;
	} cell_ctl_t;

	// map float bits to an unsigned key in ieee total order
	function automatic logic [31:0] order_key(input logic [31:0] b);
		order_key = b[31] ? ~b : (b | 32'h8000_0000);
	endfunction

endpackage

FILE: src/cle_cell.sv
// one table entry; the row of cells stays sorted in ieee total order
// a new label pushes the larger entries one cell up, a drain pulls all entries one cell down
module cle_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  cle_pkg::cell_ctl_t ctl,
	input  logic [31:0]        label,
	input  logic               lower_gt,
	input  cle_pkg::cell_t     lower,
	input  cle_pkg::cell_t     upper,
	output cle_pkg::cell_t     cur,
	output logic               hit,
	output logic               gt
);
	logic                     vld_q;
	logic [31:0]              key_q;
	logic [cle_pkg::CntW-1:0] cnt_q;
	logic                     take_lower;
	logic                     take_label;

	assign hit = vld_q && (key_q == label);
	// an empty cell counts as larger than any label
	assign gt  = !vld_q || (cle_pkg::order_key(key_q) > cle_pkg::order_key(label));
	assign take_lower = ctl.ins && gt && lower_gt;
	assign take_label = ctl.ins && gt && !lower_gt;
	assign cur = '{vld: vld_q, key: key_q, cnt: cnt_q};

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.clr) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= upper.vld;
		end else if (take_lower) begin
			vld_q <= lower.vld;
		end else if (take_label) begin
			vld_q <= 1'b1;
		end
	end

	// key and count: drain, push up, insert or bump
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q <= upper.key;
			cnt_q <= upper.cnt;
		end else if (take_lower) begin
			key_q <= lower.key;
			cnt_q <= lower.cnt;
		end else if (take_label) begin
			key_q <= label;
			cnt_q <= cle_pkg::CntW'(1);
		end else if (ctl.upd && hit) begin
			cnt_q <= cnt_q + cle_pkg::CntW'(1);
		end
	end
endmodule

FILE: src/cle_log2.sv
// iterative log2 in q.16: leading one, then one squaring per cycle
module cle_log2 (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [cle_pkg::CntW-1:0] x,
	output logic                   done,
	output logic [cle_pkg::LogW-1:0] y
);
	localparam int EW = cle_pkg::LogW - 16;

	logic [31:0] m_q;
	logic [4:0]  step_q;
	logic        busy_q;
	logic [15:0] frac_q;
	logic [EW-1:0] e_q;
	logic [EW-1:0] lead;
	logic [63:0] sq;
	logic [33:0] msq;

	// leading one position
	always_comb begin
		lead = '0;
		for (int i = 0; i < cle_pkg::CntW; i++) begin
			if (x[i]) lead = EW'(i);
		end
	end

	assign sq  = 64'(m_q) * 64'(m_q);
	assign msq = sq[63:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'd15) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			e_q    <= lead;
			m_q    <= 32'(({32'd0, x} << 30) >> lead);
			frac_q <= '0;
		end else if (busy_q) begin
			frac_q <= {frac_q[14:0], msq[31]};
			m_q    <= msq[31] ? msq[32:1] : msq[31:0];
		end
	end

	assign y = {e_q, frac_q};
endmodule

FILE: src/cle_div.sv
// restoring divider, one quotient bit per cycle
module cle_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [cle_pkg::AccW-1:0] num,
	input  logic [cle_pkg::CntW-1:0] den,
	output logic                     done,
	output logic [cle_pkg::AccW-1:0] quo
);
	localparam int CW = $clog2(cle_pkg::AccW + 1);

	logic [cle_pkg::AccW-1:0] n_q;
	logic [cle_pkg::CntW:0]   r_q;
	logic [cle_pkg::CntW:0]   trial;
	logic [CW-1:0]            cnt_q;
	logic                     busy_q;

	assign trial = {r_q[cle_pkg::CntW-1:0], n_q[cle_pkg::AccW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(cle_pkg::AccW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			n_q <= num;
			r_q <= '0;
			quo <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[cle_pkg::AccW-2:0], 1'b0};
			if (trial >= {1'b0, den}) begin
				r_q <= trial - {1'b0, den};
				quo <= {quo[cle_pkg::AccW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				quo <= {quo[cle_pkg::AccW-2:0], 1'b0};
			end
		end
	end
endmodule

FILE: src/class_label_entropy_unit.sv
// Class label histogram and Shannon entropy. While counting, one row is taken
// per cycle (start high, busy low, under 65536 rows taken): a row of 16 cells,
// kept sorted in ieee total order, matches the label in parallel and either bumps
// one count or, while a cell is free, opens a slot for a new label. On a last row
// busy rises: log2 n is taken, then for each distinct label (at most 16) the head
// cell is emitted, the row shifts one cell down and the iterative log2 folds its
// count into the sum; then the table is seen empty, the bit-serial divider runs
// and the run is cleared. Results are one-cycle beats marked by valid and cannot
// be stalled by the receiver: labels in ascending order, then the entropy beat
// with last_result set.
module class_label_entropy_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] class_label,
	input  logic        last_row,
	output logic        valid,
	output logic        result_kind,
	output logic [31:0] label_bits,
	output logic [18:0] entropy_q16,
	output logic        too_many_classes,
	output logic        rows_saturated,
	output logic        last_result
);
	localparam int N = cle_pkg::MaxClasses;

	cle_pkg::state_t state_q, state_d;
	cle_pkg::cell_ctl_t ctl;
	cle_pkg::cell_t cells [N];
	cle_pkg::cell_t lo_cell [N];
	cle_pkg::cell_t hi_cell [N];
	logic [N-1:0] hits;
	logic [N-1:0] gts;
	logic [N-1:0] lo_gt;

	logic [cle_pkg::UsedW-1:0] used_q;
	logic [cle_pkg::CntW-1:0]  rows_q;
	logic tmc_q, rsat_q;
	logic [cle_pkg::LogW-1:0]  ln_q;
	logic [cle_pkg::AccW-1:0]  acc_q;
	logic [cle_pkg::CntW-1:0]  pick_cnt_q;
	logic [31:0]               lab;
	logic                      acc_ok;
	logic                      log_go, log_done, div_go, div_done;
	logic [cle_pkg::CntW-1:0]  log_x;
	logic [cle_pkg::LogW-1:0]  log_y;
	logic [cle_pkg::AccW-1:0]  quo;
	logic                      row_take;
	logic [cle_pkg::LogW-1:0]  ldiff;

	assign lab = (class_label == 32'h8000_0000) ? 32'd0 : class_label;
	assign acc_ok = start && !busy;
	assign row_take = acc_ok && (rows_q < cle_pkg::CntW'(cle_pkg::MaxRows));
	assign busy = (state_q != cle_pkg::ST_COUNT);

	// table cells; cell 0 is the head and holds the smallest label
	assign lo_gt = {gts[N-2:0], 1'b0};
	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			if (g == 0) begin : g_head
				assign lo_cell[g] = '0;
			end else begin : g_body
				assign lo_cell[g] = cells[g-1];
			end
			if (g == N - 1) begin : g_tail
				assign hi_cell[g] = '0;
			end else begin : g_link
				assign hi_cell[g] = cells[g+1];
			end
			cle_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl), .label(lab),
				.lower_gt(lo_gt[g]), .lower(lo_cell[g]), .upper(hi_cell[g]),
				.cur(cells[g]), .hit(hits[g]), .gt(gts[g])
			);
		end
	endgenerate

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cle_pkg::ST_COUNT: if (acc_ok && last_row) state_d = cle_pkg::ST_LOGN;
			cle_pkg::ST_LOGN:  if (log_done) state_d = cle_pkg::ST_EMIT;
			cle_pkg::ST_EMIT:  if (cells[0].vld) state_d = cle_pkg::ST_LOGC;
				else state_d = cle_pkg::ST_DIV;
			cle_pkg::ST_LOGC:  if (log_done) state_d = cle_pkg::ST_EMIT;
			cle_pkg::ST_DIV:   if (div_done) state_d = cle_pkg::ST_DONE;
			cle_pkg::ST_DONE:  state_d = cle_pkg::ST_COUNT;
			default:           state_d = cle_pkg::ST_COUNT;
		endcase
	end

	// state outputs: cell controls and unit starts
	always_comb begin
		ctl       = '0;
		ctl.upd   = row_take;
		ctl.ins   = row_take && (hits == '0) && (used_q < cle_pkg::UsedW'(N));
		ctl.shift = (state_q == cle_pkg::ST_EMIT) && cells[0].vld;
		ctl.clr   = (state_q == cle_pkg::ST_DONE);
		log_go    = 1'b0;
		div_go    = 1'b0;
		case (state_q)
			cle_pkg::ST_COUNT: log_go = start && last_row;
			cle_pkg::ST_EMIT: begin
				log_go = cells[0].vld;
				div_go = !cells[0].vld;
			end
			default: begin
				log_go = 1'b0;
			end
		endcase
	end

	assign log_x = (state_q == cle_pkg::ST_COUNT)
		? (row_take ? rows_q + cle_pkg::CntW'(1) : rows_q) : cells[0].cnt;
	assign ldiff = (log_y < ln_q) ? ln_q - log_y : '0;

	cle_log2 u_log (.clk(clk), .arst_n(arst_n), .go(log_go), .x(log_x),
		.done(log_done), .y(log_y));
	cle_div u_div (.clk(clk), .arst_n(arst_n), .go(div_go),
		.num(acc_q + cle_pkg::AccW'(rows_q >> 1)), .den(rows_q),
		.done(div_done), .quo(quo));

	// run state and drain bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cle_pkg::ST_COUNT;
			used_q  <= '0;
			rows_q  <= '0;
			tmc_q   <= 1'b0;
			rsat_q  <= 1'b0;
			acc_q   <= '0;
		end else begin
			state_q <= state_d;
			if (acc_ok) begin
				if (row_take) begin
					rows_q <= rows_q + cle_pkg::CntW'(1);
					if (hits == '0) begin
						if (used_q < cle_pkg::UsedW'(N)) used_q <= used_q + cle_pkg::UsedW'(1);
						else tmc_q <= 1'b1;
					end
				end else begin
					rsat_q <= 1'b1;
				end
			end
			if (state_q == cle_pkg::ST_LOGC && log_done) begin
				acc_q <= acc_q + cle_pkg::AccW'(pick_cnt_q) * cle_pkg::AccW'(ldiff);
			end
			if (state_q == cle_pkg::ST_DONE) begin
				used_q <= '0;
				rows_q <= '0;
				tmc_q  <= 1'b0;
				rsat_q <= 1'b0;
				acc_q  <= '0;
			end
		end
	end

	// count of the head cell as it leaves, and log2 n
	always_ff @(posedge clk) begin
		if (state_q == cle_pkg::ST_EMIT && cells[0].vld) pick_cnt_q <= cells[0].cnt;
		if (state_q == cle_pkg::ST_LOGN && log_done) ln_q <= log_y;
	end

	// result beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else begin
			valid <= (state_q == cle_pkg::ST_EMIT && cells[0].vld)
				|| (state_q == cle_pkg::ST_DIV && div_done);
		end
	end

	always_ff @(posedge clk) begin
		too_many_classes <= tmc_q;
		rows_saturated   <= rsat_q;
		if (state_q == cle_pkg::ST_DIV) begin
			result_kind <= cle_pkg::RES_ENTROPY;
			label_bits  <= '0;
			entropy_q16 <= (quo > cle_pkg::AccW'(19'h7FFFF)) ? 19'h7FFFF : quo[18:0];
			last_result <= 1'b1;
		end else begin
			result_kind <= cle_pkg::RES_LABEL;
			label_bits  <= cells[0].key;
			entropy_q16 <= '0;
			last_result <= 1'b0;
		end
	end

	// no row enters while draining
	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !row_take) else $error("row taken while busy");
	// last result only on an entropy beat
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last_result) |-> result_kind == cle_pkg::RES_ENTROPY)
		else $error("last beat not entropy");
	// run clears after the entropy beat
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cle_pkg::ST_DONE) |=> (rows_q == '0 && used_q == '0))
		else $error("run not cleared");
endmodule
